// ===== rtl/core/i2cee_pkg.sv =====
package i2cee_pkg;

	localparam int unsigned MAX_PAGE_BYTES = 8;

	// operation codes
	localparam logic [1:0] OP_TICK       = 2'd0;
	localparam logic [1:0] OP_BYTE_WRITE = 2'd1;
	localparam logic [1:0] OP_PAGE_WRITE = 2'd2;
	localparam logic [1:0] OP_RAND_READ  = 2'd3;

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_START1 = 4'd1;
	localparam logic [3:0] ST_DEVW   = 4'd2;
	localparam logic [3:0] ST_ACK1   = 4'd3;
	localparam logic [3:0] ST_ADDR   = 4'd4;
	localparam logic [3:0] ST_ACK2   = 4'd5;
	localparam logic [3:0] ST_DATA   = 4'd6;
	localparam logic [3:0] ST_ACKD   = 4'd7;
	localparam logic [3:0] ST_START2 = 4'd8;
	localparam logic [3:0] ST_DEVR   = 4'd9;
	localparam logic [3:0] ST_ACK3   = 4'd10;
	localparam logic [3:0] ST_RX     = 4'd11;
	localparam logic [3:0] ST_MNACK  = 4'd12;
	localparam logic [3:0] ST_STOP   = 4'd13;

	// configuration register map
	localparam logic [2:0] PADDR_DEVICE_SELECT = 3'd0;
	localparam logic [6:0] DEVICE_SELECT_RESET = 7'd80;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  mem_address;
		logic [63:0] data_bytes;
		logic [3:0]  byte_count;
		logic        sda_in;
	} cmd_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_low;
		logic       busy_res;
		logic       done_res;
		logic       nack_seen;
		logic [7:0] rx_byte;
	} res_item_t;

endpackage

// ===== rtl/core/i2cee_if.sv =====
interface i2cee_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  mem_address;
	logic [63:0] data_bytes;
	logic [3:0]  byte_count;
	logic        sda_in;

	modport source (output valid, operation, mem_address, data_bytes, byte_count, sda_in,
		input ready);
	modport sink (input valid, operation, mem_address, data_bytes, byte_count, sda_in,
		output ready);
endinterface

interface i2cee_res_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_low;
	logic       busy_res;
	logic       done_res;
	logic       nack_seen;
	logic [7:0] rx_byte;

	modport source (output valid, scl, sda_low, busy_res, done_res, nack_seen, rx_byte,
		input ready);
	modport sink (input valid, scl, sda_low, busy_res, done_res, nack_seen, rx_byte,
		output ready);
endinterface

// ===== rtl/core/i2c_eeprom_master.sv =====
// I2C master for a 24Cxx-style serial EEPROM.
// cmd channel (valid/ready): while idle, operation 1/2/3 starts a byte write,
// page write (1..8 bytes of data_bytes, byte 0 first) or random read. Every
// other item is a tick that, while busy, runs one quarter-bit bus phase using sda_in.
// res channel (valid/ready): exactly one item per cmd item, in order, with
// the SCL level and SDA pull-down to drive, busy/done, sticky NACK flag and
// the receive byte.
// device_select is written over the APB port at byte address 0; the user must
// write it only while no item is in flight, the block itself does not enforce it.
// An accepted item is held in the input register, then the result of its one
// sequencer step is registered and visible as res.valid. Throughput: one item per
// cycle while res.ready is high, set by the input and result registers.
// When res.ready is low, the result register and input register both fill,
// then cmd.ready drops; nothing is lost and the bus state does not advance.
// Reset (arst_n low) returns the sequencer to idle, clears all flags and
// empties both registers; device_select goes back to 80.
module i2c_eeprom_master (
	input  logic               clk,
	input  logic               arst_n,
	i2cee_cmd_if.sink          cmd,
	i2cee_res_if.source        res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic                  valid_s1;
	i2cee_pkg::cmd_item_t  item_s1;
	logic                  res_valid_q;
	i2cee_pkg::res_item_t  res_q;
	i2cee_pkg::res_item_t  step_res;
	logic                  advance;
	logic                  cmd_acc;
	logic [6:0]            device_select;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cmd_acc   = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			item_s1.operation   <= cmd.operation;
			item_s1.mem_address <= cmd.mem_address;
			item_s1.data_bytes  <= cmd.data_bytes;
			item_s1.byte_count  <= cmd.byte_count;
			item_s1.sda_in      <= cmd.sda_in;
		end
	end

	i2cee_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.device_select (device_select)
	);

	i2cee_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.device_select (device_select),
		.result        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.scl       = res_q.scl;
	assign res.sda_low   = res_q.sda_low;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.nack_seen = res_q.nack_seen;
	assign res.rx_byte   = res_q.rx_byte;

	// done marks the last STOP phase, which returns to idle with both lines released
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done_res |-> !res.busy_res && res.scl && !res.sda_low)
		else $error("done without return to idle");

	// outside a sequence the bus is left released
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.busy_res |-> res.scl && !res.sda_low)
		else $error("bus driven while idle");

	// an accepted item always lands in the input register
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> valid_s1)
		else $error("accepted item lost");

	// a stalled result register keeps the input item parked
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !res.ready |=> valid_s1 && $stable(item_s1))
		else $error("input item dropped under stall");

endmodule

// ===== rtl/core/i2cee_apb_regs.sv =====
module i2cee_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [6:0]  device_select
);

	logic [6:0] dev_sel_q;
	logic       wr_en;

	assign pready = 1'b1;
	// byte lanes below bit 2 are ignored
	assign wr_en  = psel && penable && pwrite && pready &&
		(paddr[2] == i2cee_pkg::PADDR_DEVICE_SELECT[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_sel_q <= i2cee_pkg::DEVICE_SELECT_RESET;
		end else if (wr_en) begin
			dev_sel_q <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == i2cee_pkg::PADDR_DEVICE_SELECT[2]) begin
			prdata = {25'd0, dev_sel_q};
		end
	end

	assign device_select = dev_sel_q;

endmodule

// ===== rtl/core/i2cee_seq.sv =====
module i2cee_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  i2cee_pkg::cmd_item_t  item,
	input  logic [6:0]            device_select,
	output i2cee_pkg::res_item_t  result
);

	logic [3:0]  state_q,  state_d;
	logic [1:0]  phase_q,  phase_d;
	logic [3:0]  bit_q,    bit_d;
	logic [2:0]  idx_q,    idx_d;
	logic [7:0]  shift_q,  shift_d;
	logic [63:0] data_q,   data_d;
	logic [3:0]  count_q,  count_d;
	logic [7:0]  addr_q,   addr_d;
	logic [1:0]  op_q,     op_d;
	logic [7:0]  rx_q,     rx_d;
	logic        nack_q,   nack_d;

	always_comb begin
		logic       is_tx;
		logic       is_ack;
		logic       seg_done;
		logic [3:0] bc_inc;
		logic [3:0] cnt;
		logic [7:0] wdev;
		logic [3:0] nxt_st;
		logic [7:0] load;
		logic [2:0] nxt_idx;

		state_d = state_q;
		phase_d = phase_q;
		bit_d   = bit_q;
		idx_d   = idx_q;
		shift_d = shift_q;
		data_d  = data_q;
		count_d = count_q;
		addr_d  = addr_q;
		op_d    = op_q;
		rx_d    = rx_q;
		nack_d  = nack_q;

		result.scl     = 1'b1;
		result.sda_low = 1'b0;
		result.done_res = 1'b0;

		is_tx  = (state_q == i2cee_pkg::ST_DEVW) || (state_q == i2cee_pkg::ST_ADDR) ||
			(state_q == i2cee_pkg::ST_DATA) || (state_q == i2cee_pkg::ST_DEVR);
		is_ack = (state_q == i2cee_pkg::ST_ACK1) || (state_q == i2cee_pkg::ST_ACK2) ||
			(state_q == i2cee_pkg::ST_ACKD) || (state_q == i2cee_pkg::ST_ACK3);
		bc_inc = bit_q + 4'd1;
		wdev   = {device_select, 1'b0};
		seg_done = 1'b1;
		nxt_st   = i2cee_pkg::ST_IDLE;
		load     = 8'd0;
		nxt_idx  = idx_q + 3'd1;

		// saturate page length into 1..MAX_PAGE_BYTES
		cnt = item.byte_count;
		if (cnt == 4'd0) begin
			cnt = 4'd1;
		end else if (cnt > 4'(i2cee_pkg::MAX_PAGE_BYTES)) begin
			cnt = 4'(i2cee_pkg::MAX_PAGE_BYTES);
		end

		if (state_q == i2cee_pkg::ST_IDLE) begin
			if (item.operation != i2cee_pkg::OP_TICK) begin
				op_d    = item.operation;
				addr_d  = item.mem_address;
				data_d  = item.data_bytes;
				count_d = (item.operation == i2cee_pkg::OP_PAGE_WRITE) ? cnt : 4'd1;
				idx_d   = 3'd0;
				nack_d  = 1'b0;
				state_d = i2cee_pkg::ST_START1;
				phase_d = 2'd0;
				bit_d   = 4'd0;
				shift_d = 8'd0;
			end
		end else begin
			result.scl = (phase_q == 2'd1) || (phase_q == 2'd2);
			if ((state_q == i2cee_pkg::ST_START1) || (state_q == i2cee_pkg::ST_START2)) begin
				result.sda_low = phase_q[1];
			end else if (state_q == i2cee_pkg::ST_STOP) begin
				result.scl     = (phase_q != 2'd0);
				result.sda_low = !phase_q[1];
			end else if (is_tx) begin
				result.sda_low = !shift_q[7];
			end else begin
				// ACK and read bits sampled in the third phase, SCL high
				if ((phase_q == 2'd2) && is_ack && item.sda_in) begin
					nack_d = 1'b1;
				end
				if ((phase_q == 2'd2) && (state_q == i2cee_pkg::ST_RX)) begin
					rx_d = {rx_q[6:0], item.sda_in};
				end
			end

			if (phase_q == 2'd3) begin
				result.done_res = (state_q == i2cee_pkg::ST_STOP);
				if (is_tx || (state_q == i2cee_pkg::ST_RX)) begin
					bit_d = bc_inc;
					if (is_tx) begin
						shift_d = {shift_q[6:0], 1'b0};
					end
					if (bc_inc < 4'd8) begin
						phase_d  = 2'd0;
						seg_done = 1'b0;
					end
				end
				if (seg_done) begin
					unique case (state_q)
						i2cee_pkg::ST_START1: begin
							nxt_st = i2cee_pkg::ST_DEVW;
							load   = wdev;
						end
						i2cee_pkg::ST_DEVW:   nxt_st = i2cee_pkg::ST_ACK1;
						i2cee_pkg::ST_ACK1: begin
							nxt_st = i2cee_pkg::ST_ADDR;
							load   = addr_q;
						end
						i2cee_pkg::ST_ADDR:   nxt_st = i2cee_pkg::ST_ACK2;
						i2cee_pkg::ST_ACK2: begin
							if (op_q == i2cee_pkg::OP_RAND_READ) begin
								nxt_st = i2cee_pkg::ST_START2;
							end else begin
								idx_d  = 3'd0;
								nxt_st = i2cee_pkg::ST_DATA;
								load   = data_q[7:0];
							end
						end
						i2cee_pkg::ST_DATA:   nxt_st = i2cee_pkg::ST_ACKD;
						i2cee_pkg::ST_ACKD: begin
							if ({1'b0, idx_q} + 4'd1 >= count_q) begin
								nxt_st = i2cee_pkg::ST_STOP;
							end else begin
								idx_d  = nxt_idx;
								nxt_st = i2cee_pkg::ST_DATA;
								load   = data_q[{nxt_idx, 3'b000} +: 8];
							end
						end
						i2cee_pkg::ST_START2: begin
							nxt_st = i2cee_pkg::ST_DEVR;
							load   = wdev | 8'd1;
						end
						i2cee_pkg::ST_DEVR:   nxt_st = i2cee_pkg::ST_ACK3;
						i2cee_pkg::ST_ACK3:   nxt_st = i2cee_pkg::ST_RX;
						i2cee_pkg::ST_RX:     nxt_st = i2cee_pkg::ST_MNACK;
						i2cee_pkg::ST_MNACK:  nxt_st = i2cee_pkg::ST_STOP;
						default:              nxt_st = i2cee_pkg::ST_IDLE;
					endcase
					state_d = nxt_st;
					phase_d = 2'd0;
					bit_d   = 4'd0;
					shift_d = load;
				end
			end else begin
				phase_d = phase_q + 2'd1;
			end
		end

		result.busy_res  = (state_d != i2cee_pkg::ST_IDLE);
		result.nack_seen = nack_d;
		result.rx_byte   = rx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cee_pkg::ST_IDLE;
			phase_q <= 2'd0;
			bit_q   <= 4'd0;
			idx_q   <= 3'd0;
			shift_q <= 8'd0;
			data_q  <= 64'd0;
			count_q <= 4'd0;
			addr_q  <= 8'd0;
			op_q    <= 2'd0;
			rx_q    <= 8'd0;
			nack_q  <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
			data_q  <= data_d;
			count_q <= count_d;
			addr_q  <= addr_d;
			op_q    <= op_d;
			rx_q    <= rx_d;
			nack_q  <= nack_d;
		end
	end

endmodule

// ===== test/i2c_eeprom_master_tb.sv =====
`timescale 1ns / 100ps

module i2c_eeprom_master_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 8;

	// how sda_in is chosen during a transfer
	localparam int SDA_LOW    = 0;
	localparam int SDA_HIGH   = 1;
	localparam int SDA_COIN   = 2;
	localparam int SDA_SPARSE = 3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	i2cee_cmd_if cmd_ch ();
	i2cee_res_if res_ch ();

	i2c_eeprom_master dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bus sequencer mirror
	logic [6:0]  dev_sel_q = i2cee_pkg::DEVICE_SELECT_RESET;
	logic [3:0]  bus_state = i2cee_pkg::ST_IDLE;
	logic [1:0]  phase_q   = '0;
	logic [3:0]  bit_q     = '0;
	logic [2:0]  byte_q    = '0;
	logic [7:0]  shift_q   = '0;
	logic [63:0] data_q    = '0;
	logic [3:0]  count_q   = '0;
	logic [7:0]  addr_q    = '0;
	logic [1:0]  op_q      = '0;
	logic [7:0]  rx_q      = '0;
	logic        nack_q    = 1'b0;

	i2cee_pkg::cmd_item_t cmd_backlog[$];
	i2cee_pkg::res_item_t predicted_bus[$];
	i2cee_pkg::cmd_item_t cmd_out;
	i2cee_pkg::res_item_t want;

	int items_issued   = 0;
	int items_accepted = 0;
	int errors         = 0;
	int cycle_count    = 0;
	int send_gap       = 0;
	int stall_left     = 0;
	int gap_odds       = 4;
	bit quiet          = 1'b0;

	function automatic bit shifts_out(input logic [3:0] st);
		return st == i2cee_pkg::ST_DEVW || st == i2cee_pkg::ST_ADDR ||
			st == i2cee_pkg::ST_DATA || st == i2cee_pkg::ST_DEVR;
	endfunction

	function automatic bit samples_ack(input logic [3:0] st);
		return st == i2cee_pkg::ST_ACK1 || st == i2cee_pkg::ST_ACK2 ||
			st == i2cee_pkg::ST_ACKD || st == i2cee_pkg::ST_ACK3;
	endfunction

	function automatic void load_segment(input logic [3:0] st, input logic [7:0] load);
		bus_state = st;
		phase_q = '0;
		bit_q = '0;
		shift_q = load;
	endfunction

	function automatic void close_segment();
		logic [3:0] st;
		logic [7:0] wdev;
		st = bus_state;
		wdev = {dev_sel_q, 1'b0};
		if (shifts_out(st) || st == i2cee_pkg::ST_RX) begin
			bit_q = bit_q + 4'd1;
			if (shifts_out(st))
				shift_q = shift_q << 1;
			if (bit_q < 4'd8) begin
				phase_q = '0;
				return;
			end
		end
		case (st)
			i2cee_pkg::ST_START1: load_segment(i2cee_pkg::ST_DEVW, wdev);
			i2cee_pkg::ST_DEVW:   load_segment(i2cee_pkg::ST_ACK1, '0);
			i2cee_pkg::ST_ACK1:   load_segment(i2cee_pkg::ST_ADDR, addr_q);
			i2cee_pkg::ST_ADDR:   load_segment(i2cee_pkg::ST_ACK2, '0);
			i2cee_pkg::ST_ACK2: begin
				if (op_q == i2cee_pkg::OP_RAND_READ) begin
					load_segment(i2cee_pkg::ST_START2, '0);
				end else begin
					byte_q = '0;
					load_segment(i2cee_pkg::ST_DATA, data_q[7:0]);
				end
			end
			i2cee_pkg::ST_DATA:   load_segment(i2cee_pkg::ST_ACKD, '0);
			i2cee_pkg::ST_ACKD: begin
				if (int'(byte_q) + 1 >= int'(count_q)) begin
					load_segment(i2cee_pkg::ST_STOP, '0);
				end else begin
					byte_q = byte_q + 3'd1;
					load_segment(i2cee_pkg::ST_DATA, data_q[8*byte_q +: 8]);
				end
			end
			i2cee_pkg::ST_START2: load_segment(i2cee_pkg::ST_DEVR, wdev | 8'h01);
			i2cee_pkg::ST_DEVR:   load_segment(i2cee_pkg::ST_ACK3, '0);
			i2cee_pkg::ST_ACK3:   load_segment(i2cee_pkg::ST_RX, '0);
			i2cee_pkg::ST_RX:     load_segment(i2cee_pkg::ST_MNACK, '0);
			i2cee_pkg::ST_MNACK:  load_segment(i2cee_pkg::ST_STOP, '0);
			default:              load_segment(i2cee_pkg::ST_IDLE, '0);
		endcase
	endfunction

	// one accepted item: either latches a command or runs one quarter-bit phase
	function automatic i2cee_pkg::res_item_t step_bus(input i2cee_pkg::cmd_item_t it);
		i2cee_pkg::res_item_t r;
		logic [3:0] cnt;
		logic [3:0] st;
		logic [1:0] ph;
		logic scl_v, low_v, done_v;
		scl_v = 1'b1;
		low_v = 1'b0;
		done_v = 1'b0;
		if (bus_state == i2cee_pkg::ST_IDLE) begin
			if (it.operation != i2cee_pkg::OP_TICK) begin
				cnt = it.byte_count;
				if (cnt < 4'd1)
					cnt = 4'd1;
				if (cnt > i2cee_pkg::MAX_PAGE_BYTES)
					cnt = 4'(i2cee_pkg::MAX_PAGE_BYTES);
				op_q = it.operation;
				addr_q = it.mem_address;
				data_q = it.data_bytes;
				count_q = (it.operation == i2cee_pkg::OP_PAGE_WRITE) ? cnt : 4'd1;
				byte_q = '0;
				nack_q = 1'b0;
				load_segment(i2cee_pkg::ST_START1, '0);
			end
		end else begin
			st = bus_state;
			ph = phase_q;
			scl_v = (ph == 2'd1 || ph == 2'd2);
			if (st == i2cee_pkg::ST_START1 || st == i2cee_pkg::ST_START2) begin
				low_v = (ph >= 2'd2);
			end else if (st == i2cee_pkg::ST_STOP) begin
				scl_v = (ph != 2'd0);
				low_v = (ph <= 2'd1);
			end else if (shifts_out(st)) begin
				low_v = !shift_q[7];
			end else begin
				// ack and read bits sampled while scl is high
				if (ph == 2'd2 && samples_ack(st) && it.sda_in)
					nack_q = 1'b1;
				if (ph == 2'd2 && st == i2cee_pkg::ST_RX)
					rx_q = {rx_q[6:0], it.sda_in};
			end
			if (ph == 2'd3) begin
				done_v = (st == i2cee_pkg::ST_STOP);
				close_segment();
			end else begin
				phase_q = ph + 2'd1;
			end
		end
		r.scl = scl_v;
		r.sda_low = low_v;
		r.busy_res = (bus_state != i2cee_pkg::ST_IDLE);
		r.done_res = done_v;
		r.nack_seen = nack_q;
		r.rx_byte = rx_q;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errors++;
		end
	endfunction

	function automatic i2cee_pkg::cmd_item_t make_cmd(input logic [1:0] op,
			input logic [7:0] addr, input logic [63:0] data, input logic [3:0] cnt,
			input logic sda);
		i2cee_pkg::cmd_item_t it;
		it.operation = op;
		it.mem_address = addr;
		it.data_bytes = data;
		it.byte_count = cnt;
		it.sda_in = sda;
		return it;
	endfunction

	function automatic logic pick_sda(input int mode);
		case (mode)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			SDA_COIN: return 1'($urandom_range(0, 1));
			default:  return ($urandom_range(0, 15) == 0);
		endcase
	endfunction

	function automatic i2cee_pkg::cmd_item_t noise_tick();
		return make_cmd(i2cee_pkg::OP_TICK, 8'($urandom), {$urandom, $urandom},
			4'($urandom), 1'($urandom_range(0, 1)));
	endfunction

	function automatic void push_item(input i2cee_pkg::cmd_item_t it);
		cmd_backlog.push_back(it);
		items_issued++;
	endfunction

	// ticks from the command to the end of STOP
	function automatic int transfer_ticks(input logic [1:0] op, input logic [3:0] cnt);
		int n;
		if (op == i2cee_pkg::OP_RAND_READ)
			return 156;
		n = 1;
		if (op == i2cee_pkg::OP_PAGE_WRITE)
			n = (cnt == 0) ? 1 : (cnt > i2cee_pkg::MAX_PAGE_BYTES) ?
				i2cee_pkg::MAX_PAGE_BYTES : cnt;
		return 80 + 36 * n;
	endfunction

	// command plus exactly enough ticks to finish; some ticks carry a command
	// code, which the busy block must treat as a plain tick
	function automatic void queue_transfer(input logic [1:0] op, input logic [7:0] addr,
			input logic [63:0] data, input logic [3:0] cnt, input int sda_mode,
			input int busy_cmd_pct);
		i2cee_pkg::cmd_item_t it;
		push_item(make_cmd(op, addr, data, cnt, pick_sda(sda_mode)));
		for (int i = 0; i < transfer_ticks(op, cnt); i++) begin
			it = noise_tick();
			if ($urandom_range(0, 99) < busy_cmd_pct)
				it.operation = 2'($urandom_range(1, 3));
			it.sda_in = pick_sda(sda_mode);
			push_item(it);
		end
	endfunction

	function automatic void random_phase(input int target);
		int start;
		logic [1:0] op;
		logic [3:0] cnt;
		start = items_issued;
		while (items_issued - start < target) begin
			if ($urandom_range(0, 9) == 0) begin
				push_item(noise_tick());
			end else begin
				op = 2'($urandom_range(1, 3));
				cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, 3));
				queue_transfer(op, 8'($urandom), {$urandom, $urandom}, cnt,
					$urandom_range(0, 3), $urandom_range(0, 8));
				repeat ($urandom_range(0, 2))
					push_item(noise_tick());
			end
		end
	endfunction

	task automatic drain();
		while (items_accepted != items_issued || predicted_bus.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_device(input logic [6:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= i2cee_pkg::PADDR_DEVICE_SELECT;
		pwdata <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		dev_sel_q = value;
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[6:0] !== value) begin
			$error("device_select: expected %0h, got %0h", value, prdata[6:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// command driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predicted_bus.push_back(step_bus(cmd_out));
				items_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() > 0 && !quiet
						&& $urandom_range(1, gap_odds) == 1) begin
					send_gap = $urandom_range(0, 13);
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd_out = cmd_backlog.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.operation <= cmd_out.operation;
					cmd_ch.mem_address <= cmd_out.mem_address;
					cmd_ch.data_bytes <= cmd_out.data_bytes;
					cmd_ch.byte_count <= cmd_out.byte_count;
					cmd_ch.sda_in <= cmd_out.sda_in;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and ready stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (predicted_bus.size() == 0) begin
					$error("result item with nothing expected");
					errors++;
				end else begin
					want = predicted_bus.pop_front();
					check_field("scl", 8'(want.scl), 8'(res_ch.scl));
					check_field("sda_low", 8'(want.sda_low), 8'(res_ch.sda_low));
					check_field("busy_res", 8'(want.busy_res), 8'(res_ch.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(res_ch.done_res));
					check_field("nack_seen", 8'(want.nack_seen), 8'(res_ch.nack_seen));
					check_field("rx_byte", want.rx_byte, res_ch.rx_byte);
				end
			end
			if (quiet) begin
				res_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if ($urandom_range(1, gap_odds) == 1) begin
				stall_left = $urandom_range(0, 13);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = i2cee_pkg::OP_TICK;
		cmd_ch.mem_address = '0;
		cmd_ch.data_bytes = '0;
		cmd_ch.byte_count = '0;
		cmd_ch.sda_in = 1'b0;
		res_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed, device select still at its reset value
		push_item(make_cmd(i2cee_pkg::OP_TICK, 8'hFF, '1, 4'hF, 1'b1));
		queue_transfer(i2cee_pkg::OP_BYTE_WRITE, 8'h00, '1, 4'hF, SDA_LOW, 0);
		// page length above the limit saturates to a full page
		queue_transfer(i2cee_pkg::OP_PAGE_WRITE, 8'h5A, 64'hFEDC_BA98_7654_3210, 4'd9,
			SDA_COIN, 10);
		push_item(make_cmd(i2cee_pkg::OP_TICK, 8'h00, '0, 4'h0, 1'b0));
		drain();

		// widest device address, with command codes arriving while busy
		set_device(7'd127);
		gap_odds = $urandom_range(2, 10);
		queue_transfer(i2cee_pkg::OP_RAND_READ, 8'($urandom), {$urandom, $urandom},
			4'($urandom), SDA_COIN, 25);
		drain();

		// last part runs without idling on either side
		set_device(7'($urandom));
		quiet = 1'b1;
		random_phase(1);
		drain();

		if (predicted_bus.size() != 0)
			errors++;
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
